[sv/ip_allowlist_matcher_unit_defines.svh]
// Assertion macros shared by the matcher RTL.
`ifndef IP_ALLOWLIST_MATCHER_UNIT_DEFINES_SVH
`define IP_ALLOWLIST_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define IPAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipal check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define IPAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipal check failed");

`endif

[sv/ipal_pkg.sv]
package ipal_pkg;

    // Command codes carried on the operation port.
    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_ADD_ADDR = 2'd1,
        OP_ADD_NET  = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // IPv4-mapped form ::FFFF:a.b.c.d, upper word of the low half.
    localparam logic [31:0] V4_MAP_WORD  = 32'h0000_FFFF;
    // 96 leading ones of an IPv4 mask, the part that lands in the low half.
    localparam logic [31:0] V4_MASK_WORD = 32'hFFFF_FFFF;

endpackage

[sv/ipal_ram.sv]
module ipal_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[sv/ip_allowlist_matcher_unit.sv]
// Inserts and clears run through ST_EXEC, and done is registered out of that state.
// A lookup runs ST_EXEC, then ST_SCAN, reading one entry per cycle from both table memories in
// parallel up to the larger fill count, then ST_FLUSH, which raises done.
// busy stays high from the accepting edge until the done strobe; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties both tables; no memory clearing pass is run.
`include "ip_allowlist_matcher_unit_defines.svh"

module ip_allowlist_matcher_unit
    import ipal_pkg::*;
#(
    parameter int EXACT_ENTRIES  = 16,
    parameter int SUBNET_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic        addr_is_v4,
    input  logic [63:0] mask_hi,
    input  logic [63:0] mask_lo,
    output logic        done,
    output logic        allowed,
    output logic        status
);

    // Address widths of the two memories and widths of their fill counts.
    localparam int EAW = (EXACT_ENTRIES > 1) ? $clog2(EXACT_ENTRIES) : 1;
    localparam int NAW = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;
    localparam int ECW = $clog2(EXACT_ENTRIES + 1);
    localparam int NCW = $clog2(SUBNET_ENTRIES + 1);
    // The scan index runs up to the larger of the two tables.
    localparam int MAX_ENTRIES = (EXACT_ENTRIES > SUBNET_ENTRIES) ? EXACT_ENTRIES
                                                                  : SUBNET_ENTRIES;
    localparam int IW = $clog2(MAX_ENTRIES + 1);

    // Sequencer state and the operands of the transaction in flight.
    state_t         state_reg, state_next;
    op_t            op_reg;
    logic [127:0]   addr_reg;
    logic [127:0]   mask_reg;

    // Each table is a memory plus a fill count; entries at or above the count are never used.
    logic [ECW-1:0] exact_count_reg, exact_count_next;
    logic [NCW-1:0] net_count_reg, net_count_next;

    // Lookup scan: index of the entry being read, per-table "read data is a live entry" flags
    // that are registered in step with the memory read data, and the sticky hit.
    logic [IW-1:0]  idx_reg, idx_next;
    logic           pend_e_reg, pend_e_next;
    logic           pend_n_reg, pend_n_next;
    logic           hit_reg, hit_next;

    // Result registers, shown for exactly one cycle.
    logic           done_reg, done_next;
    logic           allowed_reg, allowed_next;
    logic           status_reg, status_next;

    // Memory ports.
    logic           exact_we;
    logic           net_we;
    logic [127:0]   exact_rdata;
    logic [255:0]   net_rdata;
    logic [IW-1:0]  idx_inc;
    logic           full_mask;
    logic           match_now;
    logic           scan_last;
    logic           accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Operand capture. IPv4 operands are mapped to ::FFFF:a.b.c.d and their masks get
    // 96 leading ones; the ignored upper bits are dropped here.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_t'(operation);
            if (addr_is_v4)
            begin
                addr_reg <= {64'd0, V4_MAP_WORD, addr_lo[31:0]};
                mask_reg <= {{64{1'b1}}, V4_MASK_WORD, mask_lo[31:0]};
            end
            else
            begin
                addr_reg <= {addr_hi, addr_lo};
                mask_reg <= {mask_hi, mask_lo};
            end
        end
    end

    // Exact table holds whole addresses. The subnet table holds the prefix, already ANDed
    // with its mask, in the upper half and the mask in the lower half.
    ipal_ram #(
        .WIDTH (128),
        .DEPTH (EXACT_ENTRIES)
    ) u_exact_ram (
        .clk   (clk),
        .we    (exact_we),
        .waddr (exact_count_reg[EAW-1:0]),
        .wdata (addr_reg),
        .raddr (idx_reg[EAW-1:0]),
        .rdata (exact_rdata)
    );

    ipal_ram #(
        .WIDTH (256),
        .DEPTH (SUBNET_ENTRIES)
    ) u_net_ram (
        .clk   (clk),
        .we    (net_we),
        .waddr (net_count_reg[NAW-1:0]),
        .wdata ({addr_reg & mask_reg, mask_reg}),
        .raddr (idx_reg[NAW-1:0]),
        .rdata (net_rdata)
    );

    // Compare the entries read in the previous cycle against the lookup address. The live
    // flags keep entries above the fill counts (stale or never written) out of the result.
    assign match_now = (pend_e_reg && (exact_rdata == addr_reg)) ||
                       (pend_n_reg && ((addr_reg & net_rdata[127:0]) == net_rdata[255:128]));

    assign full_mask = (mask_reg == {128{1'b1}});
    assign idx_inc   = idx_reg + IW'(1);
    // The scan ends once the index has passed the fill counts of both tables.
    assign scan_last = (idx_inc >= IW'(exact_count_reg)) && (idx_inc >= IW'(net_count_reg));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (op_reg == OP_LOOKUP) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result logic.
    always_comb
    begin
        exact_we         = 1'b0;
        net_we           = 1'b0;
        exact_count_next = exact_count_reg;
        net_count_next   = net_count_reg;
        idx_next         = idx_reg;
        pend_e_next      = 1'b0;
        pend_n_next      = 1'b0;
        hit_next         = hit_reg;
        done_next        = 1'b0;
        allowed_next     = 1'b0;
        status_next      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                idx_next = '0;
                hit_next = 1'b0;
                unique case (op_reg)
                    OP_LOOKUP:
                    begin
                    end
                    OP_ADD_ADDR, OP_ADD_NET:
                    begin
                        done_next = 1'b1;
                        // A subnet with a full 128-bit mask is an exact address.
                        if ((op_reg == OP_ADD_ADDR) || full_mask)
                        begin
                            if (exact_count_reg == ECW'(EXACT_ENTRIES))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                exact_we         = 1'b1;
                                exact_count_next = exact_count_reg + ECW'(1);
                            end
                        end
                        else
                        begin
                            if (net_count_reg == NCW'(SUBNET_ENTRIES))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                net_we         = 1'b1;
                                net_count_next = net_count_reg + NCW'(1);
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        done_next        = 1'b1;
                        exact_count_next = '0;
                        net_count_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                pend_e_next = (idx_reg < IW'(exact_count_reg));
                pend_n_next = (idx_reg < IW'(net_count_reg));
                idx_next    = idx_inc;
                hit_next    = hit_reg || match_now;
            end
            ST_FLUSH:
            begin
                done_next    = 1'b1;
                allowed_next = hit_reg || match_now;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            exact_count_reg <= '0;
            net_count_reg   <= '0;
            idx_reg         <= '0;
            pend_e_reg      <= 1'b0;
            pend_n_reg      <= 1'b0;
            hit_reg         <= 1'b0;
            done_reg        <= 1'b0;
            allowed_reg     <= 1'b0;
            status_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            exact_count_reg <= exact_count_next;
            net_count_reg   <= net_count_next;
            idx_reg         <= idx_next;
            pend_e_reg      <= pend_e_next;
            pend_n_reg      <= pend_n_next;
            hit_reg         <= hit_next;
            done_reg        <= done_next;
            allowed_reg     <= allowed_next;
            status_reg      <= status_next;
        end
    end

    assign done    = done_reg;
    assign allowed = allowed_reg;
    assign status  = status_reg;

    // Every transaction passes from ST_IDLE through ST_EXEC before its done strobe, so strobes never come back to back.
    `IPAL_ASSERT_NEXT(a_done_single, done, !done)
    // An accepted transaction keeps the unit busy in the following cycle.
    `IPAL_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    // Only a lookup can report a match.
    `IPAL_ASSERT_SAME(a_allowed_on_lookup, done && allowed, op_reg == OP_LOOKUP)
    // Only an insert can report a full table.
    `IPAL_ASSERT_SAME(a_status_on_insert, done && status,
                      (op_reg == OP_ADD_ADDR) || (op_reg == OP_ADD_NET))
    // Fill counts never pass the table depths.
    `IPAL_ASSERT_SAME(a_count_bound, busy || !busy,
                      (exact_count_reg <= ECW'(EXACT_ENTRIES)) &&
                      (net_count_reg <= NCW'(SUBNET_ENTRIES)))

endmodule
